// File: hw/rtl/dttf_pkg.sv
// ----------------------------------------------------------------------------
// dttf_pkg
// Shared types, character codes and parse phase codes for the decimal text
// to fixed-point converter.
// ----------------------------------------------------------------------------
package dttf_pkg;

    // Default format: unsigned Q32.32
    localparam int INT_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF = 32;
    localparam int VALUE_W       = 64;

    // Parse phase codes
    localparam int          PHASE_W = 2;
    localparam logic [1:0]  PH_INT  = 2'd0;
    localparam logic [1:0]  PH_FRAC = 2'd1;
    localparam logic [1:0]  PH_BAD  = 2'd2;

    // Fraction digit counter, saturates at the last weighted digit
    localparam int          FDIG_W          = 4;
    localparam logic [3:0]  MAX_FRAC_DIGITS = 4'd10;

    // Character codes
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_NINE = 8'h39;
    localparam logic [7:0]  CHAR_DOT  = 8'h2E;

    // One input beat: a character of the number text
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } char_beat_t;

    // One result beat
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
        logic               overflow;
    } res_beat_t;

    // 10^k, evaluated at elaboration
    function automatic longint unsigned pow10(input int k);
        longint unsigned p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

// File: hw/rtl/dttf_step.sv
// ----------------------------------------------------------------------------
// dttf_step
// Parser state and the per-character update: integer multiply-by-ten
// accumulate, fraction scale accumulate, saturation and grammar tracking.
// ----------------------------------------------------------------------------
module dttf_step #(
    parameter int INT_BITS  = dttf_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = dttf_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  dttf_pkg::char_beat_t   beat,
    output dttf_pkg::res_beat_t    result
);
    import dttf_pkg::*;

    localparam int IW = INT_BITS + 4;
    localparam int FW = FRAC_BITS + 4;

    // Parser state
    logic [PHASE_W-1:0]   phase_reg,    phase_next;
    logic [INT_BITS-1:0]  int_acc_reg,  int_acc_next;
    logic [FRAC_BITS-1:0] frac_acc_reg, frac_acc_next;
    logic [FDIG_W-1:0]    frac_dig_reg, frac_dig_next;
    logic                 sat_reg,      sat_next;

    // Updated state before the end-of-string clear
    logic [PHASE_W-1:0]   phase_upd;
    logic [INT_BITS-1:0]  int_upd;
    logic [FRAC_BITS-1:0] frac_upd;
    logic [FDIG_W-1:0]    fdig_upd;
    logic                 sat_upd;

    logic                 is_digit;
    logic                 is_dot;
    logic [3:0]           digit;
    logic [FDIG_W-1:0]    k_next;
    logic [IW-1:0]        int_wide;
    logic [FW-1:0]        frac_wide;
    logic [FRAC_BITS-1:0] scale_tab [16];
    logic [FRAC_BITS-1:0] scale_sel;
    logic [INT_BITS+FRAC_BITS-1:0] q_word;

    // Fraction weights: 2^FRAC_BITS / 10^k rounded half up, k = 1..10
    for (genvar k = 0; k < 16; k++)
    begin : g_scale
        if (k >= 1 && k <= 10)
        begin : g_used
            localparam longint unsigned P = pow10(k);
            localparam longint unsigned S = ((64'd1 << FRAC_BITS) + P / 2) / P;
            assign scale_tab[k] = FRAC_BITS'(S);
        end
        else
        begin : g_unused
            assign scale_tab[k] = '0;
        end
    end

    // Character classification
    assign is_digit = (beat.ch >= CHAR_ZERO) && (beat.ch <= CHAR_NINE);
    assign is_dot   = (beat.ch == CHAR_DOT);
    assign digit    = 4'(beat.ch - CHAR_ZERO);
    assign k_next   = frac_dig_reg + 4'd1;
    assign scale_sel = scale_tab[k_next];

    // acc * 10 + digit, as two shifted adds
    assign int_wide = ({4'b0, int_acc_reg} << 3) + ({4'b0, int_acc_reg} << 1)
                    + IW'(digit);

    // frac + digit * weight
    assign frac_wide = {4'b0, frac_acc_reg} + (FW'(digit) * FW'(scale_sel));

    // Per-character update
    always_comb
    begin
        phase_upd = phase_reg;
        int_upd   = int_acc_reg;
        frac_upd  = frac_acc_reg;
        fdig_upd  = frac_dig_reg;
        sat_upd   = sat_reg;
        if (beat.has_char)
        begin
            case (phase_reg)
                PH_INT:
                begin
                    if (is_digit)
                    begin
                        if (int_wide[IW-1:INT_BITS] != 4'd0)
                        begin
                            int_upd = '1;
                            sat_upd = 1'b1;
                        end
                        else
                        begin
                            int_upd = int_wide[INT_BITS-1:0];
                        end
                    end
                    else if (is_dot)
                    begin
                        phase_upd = PH_FRAC;
                    end
                    else
                    begin
                        phase_upd = PH_BAD;
                    end
                end
                PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        // digits past the tenth carry no weight
                        if (frac_dig_reg < MAX_FRAC_DIGITS)
                        begin
                            fdig_upd = k_next;
                            if (frac_wide[FW-1:FRAC_BITS] != 4'd0)
                            begin
                                frac_upd = '1;
                                sat_upd  = 1'b1;
                            end
                            else
                            begin
                                frac_upd = frac_wide[FRAC_BITS-1:0];
                            end
                        end
                    end
                    else
                    begin
                        phase_upd = PH_BAD;
                    end
                end
                default:
                begin
                    phase_upd = PH_BAD;
                end
            endcase
        end
    end

    // Result built from the updated state
    assign q_word          = {int_upd, frac_upd};
    assign result.value    = VALUE_W'(q_word);
    assign result.ok       = (phase_upd == PH_INT) || (phase_upd == PH_FRAC);
    assign result.overflow = sat_upd;

    // Commit on a consumed beat; end of string returns to the start state
    always_comb
    begin
        phase_next    = phase_reg;
        int_acc_next  = int_acc_reg;
        frac_acc_next = frac_acc_reg;
        frac_dig_next = frac_dig_reg;
        sat_next      = sat_reg;
        if (step_en)
        begin
            if (beat.last)
            begin
                phase_next    = PH_INT;
                int_acc_next  = '0;
                frac_acc_next = '0;
                frac_dig_next = '0;
                sat_next      = 1'b0;
            end
            else
            begin
                phase_next    = phase_upd;
                int_acc_next  = int_upd;
                frac_acc_next = frac_upd;
                frac_dig_next = fdig_upd;
                sat_next      = sat_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_INT;
            int_acc_reg  <= '0;
            frac_acc_reg <= '0;
            frac_dig_reg <= '0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            int_acc_reg  <= int_acc_next;
            frac_acc_reg <= frac_acc_next;
            frac_dig_reg <= frac_dig_next;
            sat_reg      <= sat_next;
        end
    end

endmodule

// File: hw/rtl/decimal_text_to_fixed_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_core
// Converts an unsigned decimal text, one character per beat, into an
// unsigned Q(INT_BITS).(FRAC_BITS) value with grammar-ok and overflow flags.
// ----------------------------------------------------------------------------
// One character beat is taken every clock cycle, except while a last beat
// waits in the input register for the result slot. A beat is registered on
// entry, and the parser state is updated from that register; the beat
// marked last also loads the result register that drives res_beat. The
// combinational multiply-by-ten add of the integer part and the weighted add
// of the fraction part in dttf_step set this rate.
// The result register frees as soon as it is taken, and character beats
// keep flowing while it waits; only a second last beat waits for the slot.
// Fraction digits past the tenth are accepted and add nothing; the reported
// value keeps the low 64 bits of integer and fraction parts side by side.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_core #(
    parameter int INT_BITS  = dttf_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = dttf_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  dttf_pkg::char_beat_t  char_beat,
    output logic                  res_valid,
    input  logic                  res_stall,
    output dttf_pkg::res_beat_t   res_beat
);
    import dttf_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    char_beat_t  s1_beat_reg;
    logic        out_valid_reg, out_valid_next;
    res_beat_t   out_beat_reg;
    res_beat_t   step_result;
    logic        out_free;
    logic        s1_adv;
    logic        char_take;

    // Handshake control
    assign out_free   = !out_valid_reg || !res_stall;
    assign s1_adv     = s1_valid_reg && (!s1_beat_reg.last || out_free);
    assign char_stall = s1_valid_reg && !s1_adv;
    assign char_take  = char_valid && !char_stall;

    assign s1_valid_next  = char_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (s1_adv && s1_beat_reg.last) ? 1'b1
                          : (res_stall ? out_valid_reg : 1'b0);

    // Parser
    dttf_step #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_adv),
        .beat    (s1_beat_reg),
        .result  (step_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_take)
        begin
            s1_beat_reg <= char_beat;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_beat_reg.last)
        begin
            out_beat_reg <= step_result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_beat_reg;

    // A last beat leaving the input register always lands a result
    a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_beat_reg.last) |=> out_valid_reg)
        else $error("last beat consumed without a result");

    // A result only appears from a consumed last beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(s1_valid_reg && s1_beat_reg.last)) |=> !out_valid_reg)
        else $error("result raised without a last beat");

    // Input stalls only while a pending beat is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> (s1_valid_reg && s1_beat_reg.last && out_valid_reg && res_stall))
        else $error("input stalled without a blocked last beat");

endmodule
